### rtl/jsu_pkg.sv
`default_nettype none

package jsu_pkg;

    // One raw byte of the quoted literal.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       input_end;
    } text_item_t;

    // One decoded result.
    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] kind;
        logic       last_of_run;
    } utf8_item_t;

    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    typedef enum logic [3:0] {
        PH_WAIT  = 4'd0,
        PH_BODY  = 4'd1,
        PH_ESC   = 4'd2,
        PH_HEXA  = 4'd3,
        PH_SURBS = 4'd4,
        PH_SURU  = 4'd5,
        PH_HEXB  = 4'd6,
        PH_SKIP  = 4'd7
    } phase_t;

    localparam int MAX_RESULTS = 4;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int IDX_W       = $clog2(MAX_RESULTS);

    // All results caused by one request, first result in bytes[0].
    typedef struct packed {
        logic [CNT_W-1:0]            count;
        logic [1:0]                  kind;
        logic [MAX_RESULTS-1:0][7:0] bytes;
    } bundle_t;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CTRL_LIMIT = 8'h20;

    localparam logic [7:0] BYTE_BS  = 8'h08;
    localparam logic [7:0] BYTE_FF  = 8'h0C;
    localparam logic [7:0] BYTE_LF  = 8'h0A;
    localparam logic [7:0] BYTE_CR  = 8'h0D;
    localparam logic [7:0] BYTE_TAB = 8'h09;

    localparam logic [15:0] SUR_HIGH_LO = 16'hD800;
    localparam logic [15:0] SUR_HIGH_HI = 16'hDBFF;
    localparam logic [15:0] SUR_LOW_LO  = 16'hDC00;
    localparam logic [15:0] SUR_LOW_HI  = 16'hDFFF;

    localparam logic [20:0] UTF8_LIM1 = 21'h00080;
    localparam logic [20:0] UTF8_LIM2 = 21'h00800;
    localparam logic [20:0] SUPP_BASE = 21'h10000;

    // Returns {valid, nibble}.
    function automatic logic [4:0] hex_digit(logic [7:0] c);
        logic [7:0] v;
        v = 8'd0;
        if (c inside {[8'h30:8'h39]}) begin
            v = c - 8'h30;
            return {1'b1, v[3:0]};
        end
        if (c inside {[8'h61:8'h66]}) begin
            v = c - 8'h57;
            return {1'b1, v[3:0]};
        end
        if (c inside {[8'h41:8'h46]}) begin
            v = c - 8'h37;
            return {1'b1, v[3:0]};
        end
        return 5'd0;
    endfunction

    function automatic bundle_t encode_utf8(logic [20:0] cp);
        bundle_t r;
        r      = '0;
        r.kind = KIND_DATA;
        if (cp < UTF8_LIM1) begin
            r.count    = CNT_W'(1);
            r.bytes[0] = cp[7:0];
        end else if (cp < UTF8_LIM2) begin
            r.count    = CNT_W'(2);
            r.bytes[0] = {3'b110, cp[10:6]};
            r.bytes[1] = {2'b10, cp[5:0]};
        end else if (cp < SUPP_BASE) begin
            r.count    = CNT_W'(3);
            r.bytes[0] = {4'b1110, cp[15:12]};
            r.bytes[1] = {2'b10, cp[11:6]};
            r.bytes[2] = {2'b10, cp[5:0]};
        end else begin
            r.count    = CNT_W'(4);
            r.bytes[0] = {5'b11110, cp[20:18]};
            r.bytes[1] = {2'b10, cp[17:12]};
            r.bytes[2] = {2'b10, cp[11:6]};
            r.bytes[3] = {2'b10, cp[5:0]};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/jsu_decode.sv
`default_nettype none

// Scanner state and the per-byte decode into a bundle of results.
module jsu_decode (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                step,
    input  wire jsu_pkg::text_item_t item,
    output jsu_pkg::bundle_t         bundle
);

    jsu_pkg::phase_t phase_reg, phase_next;
    logic [15:0]     hex_value_reg, hex_value_next;
    logic [1:0]      hex_count_reg, hex_count_next;
    logic [9:0]      high_half_reg, high_half_next;

    logic             err;
    logic             done;
    jsu_pkg::bundle_t enc;
    logic [4:0]       digit;
    logic [15:0]      hex_shift;
    logic [20:0]      cp_pair;
    logic [7:0]       b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= jsu_pkg::PH_WAIT;
            hex_value_reg <= '0;
            hex_count_reg <= '0;
            high_half_reg <= '0;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            hex_value_reg <= hex_value_next;
            hex_count_reg <= hex_count_next;
            high_half_reg <= high_half_next;
        end
    end

    always_comb
    begin
        b              = item.in_byte;
        phase_next     = phase_reg;
        hex_value_next = hex_value_reg;
        hex_count_next = hex_count_reg;
        high_half_next = high_half_reg;
        err            = 1'b0;
        done           = 1'b0;
        enc            = '0;
        enc.kind       = jsu_pkg::KIND_DATA;
        digit          = jsu_pkg::hex_digit(b);
        hex_shift      = {hex_value_reg[11:0], digit[3:0]};
        cp_pair        = jsu_pkg::SUPP_BASE + {1'b0, high_half_reg, hex_shift[9:0]};

        case (phase_reg)
            jsu_pkg::PH_BODY:
            begin
                if (b == jsu_pkg::CH_QUOTE)
                    done = 1'b1;
                else if (b < jsu_pkg::CTRL_LIMIT)
                    err = 1'b1;
                else if (b == jsu_pkg::CH_BSLASH)
                    phase_next = jsu_pkg::PH_ESC;
                else
                begin
                    enc.count    = jsu_pkg::CNT_W'(1);
                    enc.bytes[0] = b;
                end
            end
            jsu_pkg::PH_ESC:
            begin
                phase_next   = jsu_pkg::PH_BODY;
                enc.count    = jsu_pkg::CNT_W'(1);
                case (b)
                    jsu_pkg::CH_QUOTE:  enc.bytes[0] = jsu_pkg::CH_QUOTE;
                    jsu_pkg::CH_BSLASH: enc.bytes[0] = jsu_pkg::CH_BSLASH;
                    jsu_pkg::CH_SLASH:  enc.bytes[0] = jsu_pkg::CH_SLASH;
                    jsu_pkg::CH_B:      enc.bytes[0] = jsu_pkg::BYTE_BS;
                    jsu_pkg::CH_F:      enc.bytes[0] = jsu_pkg::BYTE_FF;
                    jsu_pkg::CH_N:      enc.bytes[0] = jsu_pkg::BYTE_LF;
                    jsu_pkg::CH_R:      enc.bytes[0] = jsu_pkg::BYTE_CR;
                    jsu_pkg::CH_T:      enc.bytes[0] = jsu_pkg::BYTE_TAB;
                    jsu_pkg::CH_U:
                    begin
                        enc.count      = '0;
                        hex_value_next = '0;
                        hex_count_next = '0;
                        phase_next     = jsu_pkg::PH_HEXA;
                    end
                    default:
                    begin
                        enc.count = '0;
                        err       = 1'b1;
                    end
                endcase
            end
            jsu_pkg::PH_HEXA, jsu_pkg::PH_HEXB:
            begin
                if (!digit[4])
                    err = 1'b1;
                else
                begin
                    hex_value_next = hex_shift;
                    if (hex_count_reg != 2'd3)
                        hex_count_next = hex_count_reg + 2'd1;
                    else
                    begin
                        hex_count_next = '0;
                        if (phase_reg == jsu_pkg::PH_HEXA)
                        begin
                            if (hex_shift inside {[jsu_pkg::SUR_HIGH_LO:jsu_pkg::SUR_HIGH_HI]})
                            begin
                                // The offset from the high surrogate base is the low ten bits.
                                high_half_next = hex_shift[9:0];
                                phase_next     = jsu_pkg::PH_SURBS;
                            end
                            else if (hex_shift inside
                                     {[jsu_pkg::SUR_LOW_LO:jsu_pkg::SUR_LOW_HI]})
                                err = 1'b1;
                            else
                            begin
                                enc        = jsu_pkg::encode_utf8({5'd0, hex_shift});
                                phase_next = jsu_pkg::PH_BODY;
                            end
                        end
                        else
                        begin
                            if (hex_shift inside {[jsu_pkg::SUR_LOW_LO:jsu_pkg::SUR_LOW_HI]})
                            begin
                                enc        = jsu_pkg::encode_utf8(cp_pair);
                                phase_next = jsu_pkg::PH_BODY;
                            end
                            else
                                err = 1'b1;
                        end
                    end
                end
            end
            jsu_pkg::PH_SURBS:
            begin
                if (b == jsu_pkg::CH_BSLASH)
                    phase_next = jsu_pkg::PH_SURU;
                else
                    err = 1'b1;
            end
            jsu_pkg::PH_SURU:
            begin
                if (b == jsu_pkg::CH_U)
                begin
                    hex_value_next = '0;
                    hex_count_next = '0;
                    phase_next     = jsu_pkg::PH_HEXB;
                end
                else
                    err = 1'b1;
            end
            jsu_pkg::PH_SKIP:
            begin
                if (b == jsu_pkg::CH_QUOTE)
                    phase_next = jsu_pkg::PH_BODY;
                else if (item.input_end)
                    phase_next = jsu_pkg::PH_WAIT;
            end
            default:
            begin
                if (b == jsu_pkg::CH_QUOTE)
                    phase_next = jsu_pkg::PH_BODY;
                else
                    err = 1'b1;
            end
        endcase

        // Running out of input anywhere inside a literal is an error.
        if (!done && !err && item.input_end &&
            phase_next != jsu_pkg::PH_WAIT && phase_next != jsu_pkg::PH_SKIP)
            err = 1'b1;

        bundle = enc;
        if (err)
        begin
            phase_next   = item.input_end ? jsu_pkg::PH_WAIT : jsu_pkg::PH_SKIP;
            bundle       = '0;
            bundle.count = jsu_pkg::CNT_W'(1);
            bundle.kind  = jsu_pkg::KIND_ERROR;
        end
        else if (done)
        begin
            phase_next   = jsu_pkg::PH_WAIT;
            bundle       = '0;
            bundle.count = jsu_pkg::CNT_W'(1);
            bundle.kind  = jsu_pkg::KIND_DONE;
        end
    end

    // A status result always stands alone.
    a_status_single: assert property (@(posedge clk) disable iff (!rst_n)
        step && bundle.kind != jsu_pkg::KIND_DATA |-> bundle.count == jsu_pkg::CNT_W'(1))
        else $error("status bundle with more than one result");

endmodule

`default_nettype wire

### rtl/jsu_serial.sv
`default_nettype none

// Result register that hands out a bundle one result per transfer.
module jsu_serial (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                load,
    input  wire jsu_pkg::bundle_t    bundle,
    output logic                     free,
    output logic                     valid,
    input  wire logic                stall,
    output jsu_pkg::utf8_item_t      result
);

    logic                      valid_reg, valid_next;
    jsu_pkg::bundle_t          bun_reg, bun_next;
    logic [jsu_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic                      last;
    logic                      fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bun_reg <= bun_next;
    end

    always_comb
    begin
        last       = ({1'b0, idx_reg} == bun_reg.count - jsu_pkg::CNT_W'(1));
        fire       = valid_reg && !stall;
        free       = !valid_reg || (fire && last);
        valid_next = valid_reg;
        idx_next   = idx_reg;
        bun_next   = bun_reg;
        if (load)
        begin
            valid_next = 1'b1;
            bun_next   = bundle;
            idx_next   = '0;
        end
        else if (fire)
        begin
            if (last)
                valid_next = 1'b0;
            else
                idx_next = idx_reg + jsu_pkg::IDX_W'(1);
        end
    end

    assign valid              = valid_reg;
    assign result.out_byte    = bun_reg.bytes[idx_reg];
    assign result.kind        = bun_reg.kind;
    assign result.last_of_run = last;

    a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> {1'b0, idx_reg} < bun_reg.count)
        else $error("result index past end of bundle");

    a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> free && bundle.count != '0)
        else $error("bundle loaded over a pending one or empty");

endmodule

`default_nettype wire

### rtl/json_string_unescaper_top.sv
`default_nettype none

// Channel   Direction  Handshake                 Payload
// text      in         text_valid / text_stall   jsu_pkg::text_item_t (in_byte, input_end)
// utf8      out        utf8_valid / utf8_stall   jsu_pkg::utf8_item_t (out_byte, kind, last_of_run)
//
// A request is accepted into the input register and decoded from there once it produces
// no result or the result register is free; its first result is then registered in the
// result register and offered on utf8 from there.
// A request that causes n results (n from 1 to 4) occupies the single output port until all n
// are taken, so without utf8 stalls the rate is one request per cycle when each causes at most
// one result. Requests that cause no result (backslash, hex digits) retire without the port.
// Reset clears the scanner to waiting for an opening quote; there is no clearing pass.
// While the result register is full and utf8 is stalled, one more request is held in the
// input register; text_stall rises only when that register cannot move on.
module json_string_unescaper_top (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                text_valid,
    output logic                     text_stall,
    input  wire jsu_pkg::text_item_t text,
    output logic                     utf8_valid,
    input  wire logic                utf8_stall,
    output jsu_pkg::utf8_item_t      utf8
);

    // Input register: holds one accepted request until the decoder consumes it.
    logic                in_valid_reg, in_valid_next;
    jsu_pkg::text_item_t in_item_reg, in_item_next;

    jsu_pkg::bundle_t bundle;
    logic             free;
    logic             take;
    logic             accept;

    jsu_decode u_decode (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (take),
        .item   (in_item_reg),
        .bundle (bundle)
    );

    jsu_serial u_serial (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (take && bundle.count != '0),
        .bundle (bundle),
        .free   (free),
        .valid  (utf8_valid),
        .stall  (utf8_stall),
        .result (utf8)
    );

    // The held request is decoded when it produces nothing or the result register frees up.
    always_comb
    begin
        take          = in_valid_reg && (bundle.count == '0 || free);
        text_stall    = in_valid_reg && !take;
        accept        = text_valid && !text_stall;
        in_valid_next = in_valid_reg;
        in_item_next  = in_item_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
            in_item_next  = text;
        end
        else if (take)
            in_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        in_item_reg <= in_item_next;
    end

    // A request that cannot be decoded stays put until it can.
    a_hold_pending: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !take |=> in_valid_reg && $stable(in_item_reg))
        else $error("pending request lost or changed");

    // Complete and error results carry a zero byte and end their run.
    a_status_shape: assert property (@(posedge clk) disable iff (!rst_n)
        utf8_valid && utf8.kind != jsu_pkg::KIND_DATA |-> utf8.out_byte == 8'd0 &&
        utf8.last_of_run)
        else $error("malformed status result");

    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        utf8_valid |-> utf8.kind == jsu_pkg::KIND_DATA || utf8.kind == jsu_pkg::KIND_DONE ||
        utf8.kind == jsu_pkg::KIND_ERROR)
        else $error("undefined result kind");

endmodule

`default_nettype wire

### sim/json_string_unescaper_top_test.sv
// Self-checking testbench for the JSON string unescaper.
module json_string_unescaper_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import jsu_pkg::*;

    // The watchdog gives up after this many cycles in which no request and no result moves.
    // The slowest correct stretch is the longest sender gap followed by a result that waits
    // out the longest receiver stall, plus the pipeline, so this is ample.
    localparam int IDLE_LIMIT      = 1000;
    // Cycles to keep watching after the last expected result, to catch stray results.
    localparam int SETTLE_CYCLES   = 20;
    // Number of random requests that belong to well-formed or damaged literals.
    localparam int RANDOM_REQUESTS = 270;

    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       text_valid = 1'b0;
    logic       text_stall;
    text_item_t text       = '0;
    logic       utf8_valid;
    logic       utf8_stall = 1'b0;
    utf8_item_t utf8;

    json_string_unescaper_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_valid (text_valid),
        .text_stall (text_stall),
        .text       (text),
        .utf8_valid (utf8_valid),
        .utf8_stall (utf8_stall),
        .utf8       (utf8)
    );

    // Decoder state mirrored by the testbench. It follows the scanner from reset, one
    // accepted request at a time.
    phase_t      scan_phase = PH_WAIT;
    logic [15:0] hex_acc    = '0;
    logic [1:0]  hex_digits = '0;
    logic [9:0]  high_bits  = '0;

    // Decoded bytes and status items still owed by the block, oldest first.
    utf8_item_t decoded_expected[$];

    // Bytes of the literal that is about to be sent.
    logic [7:0] literal_bytes[$];

    // When set, neither side inserts gaps or stalls, which gives back-to-back traffic.
    logic steady = 1'b0;

    int mismatches = 0;
    int stall_left = 0;
    int idle_cycles = 0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Returns {is_hex, value}. Letters a-f and A-F share their low nibble, which is
    // the digit value minus nine.
    function automatic logic [4:0] nibble_of(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= "0" && c <= "9")
            r = {1'b1, c[3:0]};
        else if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F"))
            r = {1'b1, c[3:0] + 4'd9};
        return r;
    endfunction

    // Splits a code point into its UTF-8 bytes: continuation bytes are peeled off the
    // low end first, then the lead byte takes whatever bits are left.
    task automatic utf8_sequence(input logic [20:0] cp, output logic [3:0][7:0] seq,
                                 output int len);
        logic [20:0] rest;
        int          k;
        seq  = '0;
        rest = cp;
        if (cp < 21'h80)
            len = 1;
        else if (cp < 21'h800)
            len = 2;
        else if (cp < 21'h10000)
            len = 3;
        else
            len = 4;
        for (k = len - 1; k > 0; k--)
        begin
            seq[k] = {2'b10, rest[5:0]};
            rest   = rest >> 6;
        end
        case (len)
            1: seq[0] = rest[7:0];
            2: seq[0] = {3'b110, rest[4:0]};
            3: seq[0] = {4'b1110, rest[3:0]};
            default: seq[0] = {5'b11110, rest[2:0]};
        endcase
    endtask

    // Adds one result at the end of the expected queue.
    task automatic queue_result(input utf8_item_t r);
        decoded_expected.insert(decoded_expected.size(), r);
    endtask

    // Works out what one accepted request produces and queues it.
    task automatic predict_text(input text_item_t req);
        logic [7:0]      c;
        logic            fin;
        logic            bad;
        logic            closed;
        logic [4:0]      nib;
        logic [20:0]     cp;
        logic [3:0][7:0] seq;
        int              len;
        int              k;
        utf8_item_t      r;
        c      = req.in_byte;
        fin    = req.input_end;
        bad    = 1'b0;
        closed = 1'b0;
        len    = 0;
        seq    = '0;
        case (scan_phase)
            PH_BODY:
            begin
                if (c == CH_QUOTE)
                    closed = 1'b1;
                else if (c < CTRL_LIMIT)
                    bad = 1'b1;
                else if (c == CH_BSLASH)
                    scan_phase = PH_ESC;
                else
                begin
                    seq[0] = c;
                    len    = 1;
                end
            end
            PH_ESC:
            begin
                scan_phase = PH_BODY;
                len        = 1;
                case (c)
                    CH_QUOTE, CH_BSLASH, CH_SLASH: seq[0] = c;
                    CH_B: seq[0] = BYTE_BS;
                    CH_F: seq[0] = BYTE_FF;
                    CH_N: seq[0] = BYTE_LF;
                    CH_R: seq[0] = BYTE_CR;
                    CH_T: seq[0] = BYTE_TAB;
                    CH_U:
                    begin
                        len        = 0;
                        hex_acc    = '0;
                        hex_digits = '0;
                        scan_phase = PH_HEXA;
                    end
                    default:
                    begin
                        len = 0;
                        bad = 1'b1;
                    end
                endcase
            end
            PH_HEXA, PH_HEXB:
            begin
                nib = nibble_of(c);
                if (!nib[4])
                    bad = 1'b1;
                else
                begin
                    hex_acc = {hex_acc[11:0], nib[3:0]};
                    if (hex_digits != 2'd3)
                        hex_digits = hex_digits + 2'd1;
                    else
                    begin
                        hex_digits = 2'd0;
                        if (scan_phase == PH_HEXA)
                        begin
                            if (hex_acc >= SUR_HIGH_LO && hex_acc <= SUR_HIGH_HI)
                            begin
                                high_bits  = hex_acc[9:0];
                                scan_phase = PH_SURBS;
                            end
                            else if (hex_acc >= SUR_LOW_LO && hex_acc <= SUR_LOW_HI)
                                bad = 1'b1;
                            else
                            begin
                                utf8_sequence({5'd0, hex_acc}, seq, len);
                                scan_phase = PH_BODY;
                            end
                        end
                        else if (hex_acc >= SUR_LOW_LO && hex_acc <= SUR_LOW_HI)
                        begin
                            // The pair carries twenty bits above the supplementary base.
                            cp = 21'h10000 + {1'b0, high_bits, hex_acc[9:0]};
                            utf8_sequence(cp, seq, len);
                            scan_phase = PH_BODY;
                        end
                        else
                            bad = 1'b1;
                    end
                end
            end
            PH_SURBS:
            begin
                if (c == CH_BSLASH)
                    scan_phase = PH_SURU;
                else
                    bad = 1'b1;
            end
            PH_SURU:
            begin
                if (c == CH_U)
                begin
                    hex_acc    = '0;
                    hex_digits = '0;
                    scan_phase = PH_HEXB;
                end
                else
                    bad = 1'b1;
            end
            PH_SKIP:
            begin
                if (c == CH_QUOTE)
                    scan_phase = PH_BODY;
                else if (fin)
                    scan_phase = PH_WAIT;
            end
            default:
            begin
                if (c == CH_QUOTE)
                    scan_phase = PH_BODY;
                else
                    bad = 1'b1;
            end
        endcase

        // Running out of input anywhere inside a literal is an error.
        if (!closed && !bad && fin && scan_phase != PH_WAIT && scan_phase != PH_SKIP)
            bad = 1'b1;

        if (bad)
        begin
            // Any data this request would have produced is dropped.
            scan_phase    = fin ? PH_WAIT : PH_SKIP;
            r.out_byte    = 8'h00;
            r.kind        = KIND_ERROR;
            r.last_of_run = 1'b1;
            queue_result(r);
        end
        else if (closed)
        begin
            scan_phase    = PH_WAIT;
            r.out_byte    = 8'h00;
            r.kind        = KIND_DONE;
            r.last_of_run = 1'b1;
            queue_result(r);
        end
        else
        begin
            for (k = 0; k < len; k++)
            begin
                r.out_byte    = seq[k];
                r.kind        = KIND_DATA;
                r.last_of_run = (k == len - 1);
                queue_result(r);
            end
        end
    endtask

    // Sends one request. The task is entered and left at a rising edge; valid and the
    // payload change only with nonblocking assignments, and only once per edge. Since
    // the stall is sampled before the block's registers update, the edge at which it
    // reads low is the edge that takes the request.
    task automatic send_text(input logic [7:0] b, input logic fin);
        int         gap;
        text_item_t req;
        gap           = steady ? 0 : $urandom_range(0, 9);
        req.in_byte   = b;
        req.input_end = fin;
        if (gap > 0)
        begin
            text_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        text_valid <= 1'b1;
        text       <= req;
        do @(posedge clk); while (text_stall);
        predict_text(req);
    endtask

    task automatic send_literal(input string s, input logic fin_last);
        int k;
        for (k = 0; k < s.len(); k++)
            send_text(s[k], fin_last && (k == s.len() - 1));
    endtask

    task automatic send_queued(input logic fin_last);
        int k;
        for (k = 0; k < literal_bytes.size(); k++)
            send_text(literal_bytes[k], fin_last && (k == literal_bytes.size() - 1));
    endtask

    // Holds the sender off until every request sent so far has been answered.
    task automatic wait_for_results();
        text_valid <= 1'b0;
        do @(posedge clk); while (decoded_expected.size() != 0);
    endtask

    // Adds one byte at the end of the literal under construction.
    task automatic append_byte(input logic [7:0] v);
        literal_bytes.insert(literal_bytes.size(), v);
    endtask

    // Appends a \uXXXX escape, each letter digit in a randomly chosen case.
    task automatic push_unicode_escape(input logic [15:0] v);
        int         k;
        logic [3:0] n;
        append_byte(CH_BSLASH);
        append_byte(CH_U);
        for (k = 3; k >= 0; k--)
        begin
            n = v[k*4 +: 4];
            if (n < 4'd10)
                append_byte(8'h30 + n);
            else
                append_byte(($urandom_range(0, 1) ? 8'h41 : 8'h61) + n - 8'd10);
        end
    endtask

    // Builds one well-formed literal from plain bytes, simple escapes, code points from
    // every UTF-8 length class and surrogate pairs.
    task automatic build_random_literal();
        int          parts;
        int          k;
        logic [7:0]  b;
        logic [15:0] cp;
        literal_bytes.delete();
        append_byte(CH_QUOTE);
        parts = $urandom_range(0, 5);
        for (k = 0; k < parts; k++)
        begin
            case ($urandom_range(0, 3))
                0:
                begin
                    do b = 8'($urandom_range(8'h20, 8'hFF));
                    while (b == CH_QUOTE || b == CH_BSLASH);
                    append_byte(b);
                end
                1:
                begin
                    case ($urandom_range(0, 7))
                        0: b = CH_QUOTE;
                        1: b = CH_BSLASH;
                        2: b = CH_SLASH;
                        3: b = CH_B;
                        4: b = CH_F;
                        5: b = CH_N;
                        6: b = CH_R;
                        default: b = CH_T;
                    endcase
                    append_byte(CH_BSLASH);
                    append_byte(b);
                end
                2:
                begin
                    case ($urandom_range(0, 3))
                        0: cp = 16'($urandom_range(16'h0000, 16'h007F));
                        1: cp = 16'($urandom_range(16'h0080, 16'h07FF));
                        2: cp = 16'($urandom_range(16'h0800, 16'hD7FF));
                        default: cp = 16'($urandom_range(16'hE000, 16'hFFFF));
                    endcase
                    push_unicode_escape(cp);
                end
                default:
                begin
                    push_unicode_escape(SUR_HIGH_LO + 16'($urandom_range(0, 1023)));
                    push_unicode_escape(SUR_LOW_LO + 16'($urandom_range(0, 1023)));
                end
            endcase
        end
        append_byte(CH_QUOTE);
    endtask

    // Printable ASCII, the top of the byte range and an empty literal pass straight through.
    task automatic test_pass_through();
        send_literal("\"a ~\"", 1'b0);
        send_text(CH_QUOTE, 1'b0);
        send_text(8'h7F, 1'b0);
        send_text(8'h80, 1'b0);
        send_text(8'hFF, 1'b0);
        send_text(CH_QUOTE, 1'b0);
        send_literal("\"\"", 1'b0);
    endtask

    task automatic test_simple_escapes();
        send_literal("\"\\\"\\\\\\/\\b\\f\\n\\r\\t\"", 1'b0);
    endtask

    // Code points at both ends of the one-, two- and three-byte UTF-8 length classes, including zero, with
    // hex digits in both cases.
    task automatic test_unicode_escapes();
        send_literal("\"\\u0000\\u007F\\u0080\\u07ff\\u0800\\uFFFF\\uaBcD\"", 1'b0);
    endtask

    // The lowest and highest supplementary code points.
    task automatic test_surrogate_pairs();
        send_literal("\"\\uD800\\uDC00\\udbff\\uDFFF\"", 1'b0);
    endtask

    // Each malformed literal is followed by a fresh quote, which the discarding state
    // takes as the opening of a new literal without reporting anything.
    task automatic test_malformed_literals();
        // A first byte that is not a quote, then bytes that are discarded.
        send_literal("xyz", 1'b0);
        send_literal("\"ok\"", 1'b0);
        // A control byte inside the literal.
        send_text(CH_QUOTE, 1'b0);
        send_text(8'h1F, 1'b0);
        send_literal("\"\"", 1'b0);
        send_text(CH_QUOTE, 1'b0);
        send_text(8'h00, 1'b0);
        send_literal("\"\"", 1'b0);
        // An unknown escape and a bad hex digit.
        send_literal("\"\\x", 1'b0);
        send_literal("\"\\u12G4\"", 1'b0);
        // A low surrogate on its own.
        send_literal("\"\\uDC00\"", 1'b0);
        // A high surrogate without a backslash, without a 'u', or followed by another
        // high surrogate.
        send_literal("\"\\uD800x\"", 1'b0);
        send_literal("\"\\uD800\\x\"", 1'b0);
        send_literal("\"\\uD800\\uD800\"", 1'b0);
        send_literal("\"\"", 1'b0);
    endtask

    // Input that ends before the literal is closed.
    task automatic test_truncated_input();
        // Ends on a data byte: only the error is reported for that byte.
        send_literal("\"ab", 1'b1);
        // An opening quote that is the last byte.
        send_literal("\"", 1'b1);
        // Ends after a backslash, and on the last hex digit of a code point.
        send_literal("\"\\", 1'b1);
        send_literal("\"\\u00e9", 1'b1);
        // A closing quote that is also the last byte completes normally.
        send_literal("\"z\"", 1'b1);
        // A stray byte with the end flag while waiting for a quote.
        send_literal("w", 1'b1);
        // The end flag while discarding returns to waiting without a result.
        send_literal("!", 1'b0);
        send_literal("q", 1'b1);
        send_literal("\"\"", 1'b0);
    endtask

    // Lets the block run dry between two literals.
    task automatic test_pause_for_results();
        send_literal("\"\\uD83D\\uDE00\"", 1'b0);
        wait_for_results();
        send_literal("\"\\u20AC\"", 1'b0);
    endtask

    // Mostly well-formed literals with random content; one in ten has a random byte put
    // somewhere, one in ten a control byte, one in ten is cut short with the end flag.
    // Now and then random noise goes between literals.
    task automatic test_random_literals();
        int         sent;
        int         sel;
        int         pos;
        int         k;
        int         noise;
        logic       fin_last;
        sent = 0;
        while (sent < RANDOM_REQUESTS)
        begin
            steady = ($urandom_range(0, 5) == 0);
            build_random_literal();
            fin_last = ($urandom_range(0, 7) == 0);
            sel      = $urandom_range(0, 9);
            if (sel == 0)
            begin
                pos = $urandom_range(0, literal_bytes.size() - 1);
                literal_bytes[pos] = 8'($urandom_range(0, 255));
            end
            else if (sel == 1)
            begin
                pos = $urandom_range(1, literal_bytes.size() - 1);
                literal_bytes[pos] = 8'($urandom_range(0, 8'h1F));
            end
            else if (sel == 2)
            begin
                pos = $urandom_range(1, literal_bytes.size() - 1);
                while (literal_bytes.size() > pos)
                    void'(literal_bytes.pop_back());
                fin_last = 1'b1;
            end
            sent += literal_bytes.size();
            send_queued(fin_last);
            if ($urandom_range(0, 9) == 0)
            begin
                noise = $urandom_range(1, 4);
                for (k = 0; k < noise; k++)
                    send_text(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
            end
            if ($urandom_range(0, 19) == 0)
                wait_for_results();
        end
        steady = 1'b0;
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_pass_through();
        test_simple_escapes();
        test_unicode_escapes();
        test_surrogate_pairs();
        test_malformed_literals();
        test_truncated_input();
        test_pause_for_results();
        test_random_literals();

        // Every request is in; wait for the last results, then a little longer so that
        // any result the block should not have produced shows up.
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Receiver: after each result it takes, it stalls for a random number of cycles unless steady is set.
    always @(posedge clk)
    begin
        if (rst_n && utf8_valid && !utf8_stall)
            stall_left = steady ? 0 : $urandom_range(0, 9);
        if (stall_left > 0)
        begin
            utf8_stall <= 1'b1;
            stall_left = stall_left - 1;
        end
        else
            utf8_stall <= 1'b0;
    end

    // Every result the block hands over is checked against the oldest expectation.
    always @(posedge clk)
    begin : check_result
        utf8_item_t want;
        if (rst_n && utf8_valid && !utf8_stall)
        begin
            if (decoded_expected.size() == 0)
            begin
                $display("%0t ns: unexpected result, got out_byte %02h kind %0d last %0d",
                         $time, utf8.out_byte, utf8.kind, utf8.last_of_run);
                mismatches++;
            end
            else
            begin
                want = decoded_expected.pop_front();
                if (utf8.out_byte !== want.out_byte)
                begin
                    $display("%0t ns: out_byte expected %02h, got %02h",
                             $time, want.out_byte, utf8.out_byte);
                    mismatches++;
                end
                if (utf8.kind !== want.kind)
                begin
                    $display("%0t ns: kind expected %0d, got %0d", $time, want.kind, utf8.kind);
                    mismatches++;
                end
                if (utf8.last_of_run !== want.last_of_run)
                begin
                    $display("%0t ns: last_of_run expected %0d, got %0d",
                             $time, want.last_of_run, utf8.last_of_run);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: ends the run if neither channel moves for too long.
    always @(posedge clk)
    begin
        if ((text_valid && !text_stall) || (utf8_valid && !utf8_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t ns: timeout, nothing moved for %0d cycles", $time, IDLE_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

endmodule
